// ===== rtl/hcbp_pkg.sv =====
// ============================================================================
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ============================================================================
`default_nettype none

package hcbp_pkg;

   // Code table shape
   localparam int MAX_CODE_LEN = 32;
   localparam int ALPHABET     = 256;
   localparam int BITS_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 8;
   localparam int TABLE_DEPTH  = 1 << SYM_W;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN > BITS_W) ? BITS_W : MAX_CODE_LEN;

   // Work register: one byte of pending bits followed by a full code
   localparam int BYTE_W = 8;
   localparam int WORK_W = BITS_W + BYTE_W;

   // Request payload packing
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMIT,
      ST_PAD,
      ST_TRAIL
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic table_write;
      logic merge;
      logic emit_code;
      logic emit_pad;
      logic emit_trail;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type in_kind;
      logic     total_zero;
      logic     total_ge8;
      logic     total_lt16;
      logic     slot_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/huffman_code_bit_packer_core.sv =====
// ============================================================================
// huffman_code_bit_packer_core
// Table-driven Huffman encoder back end: loads codes, packs code bits into
// bytes and closes a stream with a padded byte and a trailer count.
// ============================================================================
//
//  Channel   Dir   Beat contents
//  req_*     in    tuser: kind; tdata: symbol, code_length, code_bits
//  rsp_*     out   tdata: out_byte; tuser: is_trailer; tlast: last
//
//  A load writes the table entry when it is accepted. An encode reads the
//  table, merges the code behind the pending bits, then emits one byte per
//  cycle. A flush emits a padded byte if bits are pending, then the trailer.
//  The sequence stalls while the result register holds a beat and
//  rsp_tready is low.
//  Reset clears the code table through its valid bits.
// ============================================================================
`default_nettype none

module huffman_code_bit_packer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [47:46] zero
   input  wire logic [hcbp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] kind
   input  wire logic [hcbp_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] out_byte
   output logic      [hcbp_pkg::BYTE_W-1:0]         rsp_tdata,
   // [0] is_trailer
   output logic      [0:0]                          rsp_tuser,
   output logic                                     rsp_tlast
);

   hcbp_pkg::cmd_type    cmd;
   hcbp_pkg::status_type status;

   hcbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hcbp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/hcbp_table.sv =====
// ============================================================================
// hcbp_table
// Code table: length and bits per symbol, with per-entry valid bits so that
// entries never written read as the empty code.
// ============================================================================
`default_nettype none

module hcbp_table (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [hcbp_pkg::SYM_W-1:0]      wr_addr,
   input  wire logic [hcbp_pkg::LEN_W-1:0]      wr_len,
   input  wire logic [hcbp_pkg::BITS_W-1:0]     wr_bits,
   input  wire logic [hcbp_pkg::SYM_W-1:0]      rd_addr,
   output logic      [hcbp_pkg::LEN_W-1:0]      rd_len,
   output logic      [hcbp_pkg::BITS_W-1:0]     rd_bits
);

   logic [hcbp_pkg::LEN_W-1:0]  len_mem_ff  [hcbp_pkg::TABLE_DEPTH];
   logic [hcbp_pkg::BITS_W-1:0] bits_mem_ff [hcbp_pkg::TABLE_DEPTH];
   logic [hcbp_pkg::TABLE_DEPTH-1:0] vld_ff;
   logic [hcbp_pkg::LEN_W-1:0]  rd_len_ff;
   logic [hcbp_pkg::BITS_W-1:0] rd_bits_ff;
   logic                        rd_vld_ff;

   // Memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem_ff[wr_addr]  <= wr_len;
         bits_mem_ff[wr_addr] <= wr_bits;
      end
   end

   // Valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_len_ff  <= len_mem_ff[rd_addr];
      rd_bits_ff <= bits_mem_ff[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   // Unwritten entries read as the empty code
   assign rd_len  = rd_vld_ff ? rd_len_ff  : '0;
   assign rd_bits = rd_vld_ff ? rd_bits_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/hcbp_ctrl.sv =====
// ============================================================================
// hcbp_ctrl
// Controller: sequences table loads, code merging, byte emission and flush.
// ============================================================================
`default_nettype none

module hcbp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire hcbp_pkg::status_type   status,
   output hcbp_pkg::cmd_type           cmd
);

   hcbp_pkg::state_type state_ff, state_in;
   logic                accept;

   assign req_tready = (state_ff == hcbp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (accept) begin
               case (status.in_kind)
                  hcbp_pkg::KIND_ENCODE: state_in = hcbp_pkg::ST_MERGE;
                  hcbp_pkg::KIND_FLUSH: begin
                     state_in = status.total_zero ? hcbp_pkg::ST_TRAIL : hcbp_pkg::ST_PAD;
                  end
                  default: state_in = hcbp_pkg::ST_IDLE;
               endcase
            end
         end
         hcbp_pkg::ST_MERGE: state_in = hcbp_pkg::ST_EMIT;
         hcbp_pkg::ST_EMIT: begin
            if (!status.total_ge8) begin
               state_in = hcbp_pkg::ST_IDLE;
            end else if (status.slot_free && status.total_lt16) begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         hcbp_pkg::ST_PAD: begin
            if (status.slot_free) state_in = hcbp_pkg::ST_TRAIL;
         end
         hcbp_pkg::ST_TRAIL: begin
            if (status.slot_free) state_in = hcbp_pkg::ST_IDLE;
         end
         default: state_in = hcbp_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.table_write = accept && (status.in_kind == hcbp_pkg::KIND_LOAD);
      case (state_ff)
         hcbp_pkg::ST_MERGE: cmd.merge      = 1'b1;
         hcbp_pkg::ST_EMIT:  cmd.emit_code  = status.total_ge8 && status.slot_free;
         hcbp_pkg::ST_PAD:   cmd.emit_pad   = status.slot_free;
         hcbp_pkg::ST_TRAIL: cmd.emit_trail = status.slot_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/hcbp_datapath.sv =====
// ============================================================================
// hcbp_datapath
// Datapath: code table, bit work register and the registered result stage.
// ============================================================================
`default_nettype none

module hcbp_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hcbp_pkg::cmd_type                  cmd,
   output hcbp_pkg::status_type                    status,
   input  wire logic [hcbp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [hcbp_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [hcbp_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic      [0:0]                         rsp_tuser,
   output logic                                    rsp_tlast
);

   localparam int LEN_LO  = hcbp_pkg::SYM_W;
   localparam int BITS_LO = hcbp_pkg::SYM_W + hcbp_pkg::LEN_W;

   logic [hcbp_pkg::SYM_W-1:0]  req_sym;
   logic [hcbp_pkg::LEN_W-1:0]  req_len;
   logic [hcbp_pkg::BITS_W-1:0] req_bits;
   logic [hcbp_pkg::BITS_W-1:0] len_mask;
   logic                        wr_ok;
   logic [hcbp_pkg::LEN_W-1:0]  rd_len;
   logic [hcbp_pkg::BITS_W-1:0] rd_bits;

   logic [hcbp_pkg::WORK_W-1:0] work_ff, work_in;
   logic [hcbp_pkg::LEN_W-1:0]  total_ff, total_in;
   logic [hcbp_pkg::WORK_W-1:0] code_place;
   logic [hcbp_pkg::LEN_W-1:0]  code_shift;

   logic                        out_vld_ff;
   logic [hcbp_pkg::BYTE_W-1:0] out_byte_ff;
   logic                        out_trl_ff;
   logic                        out_last_ff;

   // Request field unpacking
   assign req_sym  = req_tdata[hcbp_pkg::SYM_W-1:0];
   assign req_len  = req_tdata[LEN_LO +: hcbp_pkg::LEN_W];
   assign req_bits = req_tdata[BITS_LO +: hcbp_pkg::BITS_W];

   // Load checks and stray bit masking
   assign wr_ok = ({1'b0, req_sym} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::ALPHABET))
               && (req_len <= hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT));
   assign len_mask = hcbp_pkg::BITS_W'(((hcbp_pkg::BITS_W+1)'(1) << req_len)
                                       - (hcbp_pkg::BITS_W+1)'(1));

   hcbp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd.table_write && wr_ok),
      .wr_addr (req_sym),
      .wr_len  (req_len),
      .wr_bits (req_bits & len_mask),
      .rd_addr (req_sym),
      .rd_len  (rd_len),
      .rd_bits (rd_bits)
   );

   // Code left-aligned, then placed behind the pending bits
   assign code_shift = hcbp_pkg::LEN_W'(hcbp_pkg::BITS_W) - rd_len;
   assign code_place = ({rd_bits, hcbp_pkg::BYTE_W'(0)} << code_shift) >> total_ff[2:0];

   // Work register update
   always_comb begin
      work_in  = work_ff;
      total_in = total_ff;
      if (cmd.merge) begin
         work_in  = {work_ff[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_W],
                     hcbp_pkg::BITS_W'(0)} | code_place;
         total_in = total_ff + rd_len;
      end else if (cmd.emit_code) begin
         work_in  = work_ff << hcbp_pkg::BYTE_W;
         total_in = total_ff - hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W);
      end else if (cmd.emit_trail) begin
         work_in  = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= '0;
         total_ff <= '0;
      end else begin
         work_ff  <= work_in;
         total_ff <= total_in;
      end
   end

   // Result stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit_code || cmd.emit_pad || cmd.emit_trail) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   // Result stage payload
   always_ff @(posedge clock) begin
      if (cmd.emit_code || cmd.emit_pad) begin
         out_byte_ff <= work_ff[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_W];
         out_trl_ff  <= 1'b0;
         out_last_ff <= cmd.emit_code && status.total_lt16;
      end else if (cmd.emit_trail) begin
         out_byte_ff <= hcbp_pkg::BYTE_W'(hcbp_pkg::BYTE_W)
                        - {5'b0, total_ff[2:0]};
         out_trl_ff  <= 1'b1;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_trl_ff;
   assign rsp_tlast  = out_last_ff;

   // Status to controller
   always_comb begin
      status.in_kind    = hcbp_pkg::kind_type'(req_tuser);
      status.total_zero = (total_ff == '0);
      status.total_ge8  = (total_ff >= hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W));
      status.total_lt16 = (total_ff < hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_W));
      status.slot_free  = !out_vld_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// ===== rtl/hcbp_checker.sv =====
// ============================================================================
// hcbp_checker
// Port-level checks for the Huffman code bit packer.
// ============================================================================
`default_nettype none

module hcbp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [hcbp_pkg::BYTE_W-1:0]       rsp_tdata,
   input wire logic [0:0]                        rsp_tuser,
   input wire logic                              rsp_tlast
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Trailer always closes its item
   a_trl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("trailer without tlast");

   // Trailer count is 1..8
   a_trl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata != 8'd0) && (rsp_tdata <= 8'd8))
      else $error("trailer count out of range");

   // No new item while an item still has results to come
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken mid item");

   // Reset empties the result stage
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
